>>> design/baro_comp_pkg.sv
// constants and register indexes shared by the barometric compensation unit
`default_nettype none
package baro_comp_pkg;

	localparam int RAW_BITS = 24;
	localparam int RAW_W    = 24;
	localparam int COEF_W   = 16;
	localparam int DT_W     = 26;
	localparam int MC_W     = 35;
	localparam int OFF_W    = 37;
	localparam int ACC_W    = 60;
	localparam int CNT_W    = 5;
	localparam int TEMP_W   = 19;
	localparam int PRES_W   = 32;
	localparam int IDX_W    = 3;

	localparam logic [RAW_W-1:0]  RAW_MASK  = RAW_W'((64'd1 << RAW_BITS) - 64'd1);
	localparam logic [TEMP_W-1:0] TEMP_BASE = TEMP_W'(2000);

	localparam logic [IDX_W-1:0] REG_SENS      = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SENS_TEMP = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFF_TEMP  = 3'd3;
	localparam logic [IDX_W-1:0] REG_REF_TEMP  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SLOPE     = 3'd5;

	localparam logic OP_TEMP = 1'b0;
	localparam logic OP_PRES = 1'b1;

endpackage
`default_nettype wire

>>> design/baro_sensor_compensation_unit.sv
// barometric sensor compensation: bit-serial shift-add multiplier, first order formulas
// a temperature word takes one product, a pressure word three in turn: offset, sensitivity and raw pressure
// throughput: one word at a time, set by the one-bit-per-cycle shift-add multiplier
// (16 steps per coefficient product, RAW_BITS steps for the raw pressure product)
// a new word is taken while the previous result still waits in the output register
// reset clears control state, calibration registers and the stored temperature difference
`default_nettype none
module baro_sensor_compensation_unit import baro_comp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [COEF_W-1:0]        cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     op,
	input  wire logic [RAW_W-1:0]         raw_reading,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          kind,
	output logic signed [TEMP_W-1:0]      temperature,
	output logic [PRES_W-1:0]             pressure
);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_FIN} state_t;
	typedef enum logic [1:0] {PH_TEMP, PH_OFF, PH_SENS, PH_PRES} phase_t;

	state_t                    state_q;
	phase_t                    phase_q;
	logic [COEF_W-1:0]         sens_q, offset_q, sens_temp_q, off_temp_q, ref_temp_q, slope_q;
	logic signed [DT_W-1:0]    temp_diff_q;
	logic [RAW_W-1:0]          raw_q;
	logic [RAW_W-1:0]          mplier_q;
	logic signed [MC_W-1:0]    mcand_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [OFF_W-1:0]   off_q;
	logic [CNT_W-1:0]          cnt_q;

	logic                      in_acc;
	logic                      out_free;
	logic [RAW_W-1:0]          raw_m;
	logic signed [DT_W-1:0]    dt_n;
	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   off_full, sens_full, t_sh, p_diff, p_sh;
	logic [TEMP_W-1:0]         temp_res;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	assign raw_m  = raw_reading & RAW_MASK;
	assign dt_n   = $signed({2'b00, raw_m}) - $signed({2'b00, ref_temp_q, 8'h00});
	assign addend = mplier_q[RAW_W-1] ? ACC_W'(mcand_q) : '0;

	assign off_full  = $signed({27'd0, offset_q, 17'd0}) + (acc_q >>> 6);
	assign sens_full = $signed({28'd0, sens_q, 16'd0}) + (acc_q >>> 7);
	assign t_sh      = acc_q >>> 23;
	assign temp_res  = t_sh[TEMP_W-1:0] + TEMP_BASE;
	assign p_diff    = (acc_q >>> 21) - ACC_W'(off_q);
	assign p_sh      = p_diff >>> 15;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q      <= '0;
			offset_q    <= '0;
			sens_temp_q <= '0;
			off_temp_q  <= '0;
			ref_temp_q  <= '0;
			slope_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENS:      sens_q      <= cfg_data;
				REG_OFFSET:    offset_q    <= cfg_data;
				REG_SENS_TEMP: sens_temp_q <= cfg_data;
				REG_OFF_TEMP:  off_temp_q  <= cfg_data;
				REG_REF_TEMP:  ref_temp_q  <= cfg_data;
				REG_SLOPE:     slope_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, datapath and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_TEMP;
			cnt_q       <= '0;
			temp_diff_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_FIN)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						raw_q   <= raw_m;
						acc_q   <= '0;
						cnt_q   <= CNT_W'(COEF_W);
						state_q <= S_MUL;
						if (op == OP_TEMP) begin
							temp_diff_q <= dt_n;
							mcand_q     <= MC_W'(dt_n);
							mplier_q    <= {slope_q, 8'h00};
							phase_q     <= PH_TEMP;
						end else begin
							mcand_q  <= MC_W'(temp_diff_q);
							mplier_q <= {off_temp_q, 8'h00};
							phase_q  <= PH_OFF;
						end
					end
				end
				S_MUL: begin
					if (cnt_q != '0) begin
						acc_q    <= (acc_q <<< 1) + addend;
						mplier_q <= mplier_q << 1;
						cnt_q    <= cnt_q - 1'b1;
					end else begin
						case (phase_q)
							PH_OFF: begin
								off_q    <= off_full[OFF_W-1:0];
								acc_q    <= '0;
								mcand_q  <= MC_W'(temp_diff_q);
								mplier_q <= {sens_temp_q, 8'h00};
								cnt_q    <= CNT_W'(COEF_W);
								phase_q  <= PH_SENS;
							end
							PH_SENS: begin
								acc_q    <= '0;
								mcand_q  <= sens_full[MC_W-1:0];
								mplier_q <= raw_q << (RAW_W - RAW_BITS);
								cnt_q    <= CNT_W'(RAW_BITS);
								phase_q  <= PH_PRES;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
						if (phase_q == PH_TEMP) begin
							kind        <= OP_TEMP;
							temperature <= temp_res;
							pressure    <= '0;
						end else begin
							kind        <= OP_PRES;
							temperature <= '0;
							pressure    <= p_sh[PRES_W-1:0];
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_MUL)
		else $error("word accepted but multiplier not started");

	a_temp_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == OP_TEMP |-> pressure == '0)
		else $error("temperature word carries a pressure value");

	a_pres_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == OP_PRES |-> temperature == '0)
		else $error("pressure word carries a temperature value");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> cnt_q <= CNT_W'(RAW_BITS))
		else $error("step count out of range");

	a_fin_only_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> phase_q == PH_TEMP || phase_q == PH_PRES)
		else $error("result stage reached from an intermediate product");

endmodule
`default_nettype wire

>>> tb/sv/baro_comp_checker.sv
// checker for the barometric compensation unit: predicts each result word and compares it
`timescale 1ns / 1ps
module baro_comp_checker import baro_comp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [COEF_W-1:0]   cfg_data,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic                op,
	input  wire logic [RAW_W-1:0]    raw_reading,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic                kind,
	input  wire logic [TEMP_W-1:0]   temperature,
	input  wire logic [PRES_W-1:0]   pressure,
	output int                       mismatches,
	output int                       pending,
	output int                       temp_words,
	output int                       pres_words
);

	typedef struct packed {
		logic              k;
		logic [TEMP_W-1:0] t;
		logic [PRES_W-1:0] p;
	} comp_word_t;

	logic [COEF_W-1:0] cal [0:5];
	longint            held_dt;
	comp_word_t        expected_words [$];

	function automatic comp_word_t compensate(input logic o, input longint raw, input longint dt);
		longint     t;
		longint     off;
		longint     sens;
		longint     p;
		longint     c_sens;
		longint     c_off;
		longint     c_sens_tc;
		longint     c_off_tc;
		longint     c_slope;
		longint     base;
		comp_word_t w;
		c_sens    = cal[REG_SENS];
		c_off     = cal[REG_OFFSET];
		c_sens_tc = cal[REG_SENS_TEMP];
		c_off_tc  = cal[REG_OFF_TEMP];
		c_slope   = cal[REG_SLOPE];
		base      = TEMP_BASE;
		w   = '0;
		w.k = o;
		if (o == OP_TEMP) begin
			t   = base + ((dt * c_slope) >>> 23);
			w.t = t[TEMP_W-1:0];
		end else begin
			off  = (c_off <<< 17) + ((c_off_tc * dt) >>> 6);
			sens = (c_sens <<< 16) + ((c_sens_tc * dt) >>> 7);
			p    = (((raw * sens) >>> 21) - off) >>> 15;
			w.p  = p[PRES_W-1:0];
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		comp_word_t want;
		comp_word_t got;
		longint     raw;
		if (!arst_n) begin
			foreach (cal[i])
				cal[i] = '0;
			held_dt = 0;
			expected_words.delete();
			mismatches = 0;
			temp_words = 0;
			pres_words = 0;
		end else begin
			if (cfg_we && cfg_index <= REG_SLOPE)
				cal[cfg_index] = cfg_data;
			if (in_valid && !in_stall) begin
				raw = raw_reading & RAW_MASK;
				if (op == OP_TEMP)
					held_dt = raw - (longint'(cal[REG_REF_TEMP]) <<< 8);
				expected_words.push_back(compensate(op, raw, held_dt));
			end
			if (out_valid && !out_stall) begin
				got.k = kind;
				got.t = temperature;
				got.p = pressure;
				if (kind == OP_TEMP)
					temp_words++;
				else
					pres_words++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: kind %0d temperature %0d pressure %0h",
							got.k, $signed(got.t), got.p);
				end else begin
					want = expected_words.pop_front();
					if (want.k !== got.k || want.t !== got.t || want.p !== got.p) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected kind %0d temperature %0d pressure %0h",
								want.k, $signed(want.t), want.p);
							$display("          got kind %0d temperature %0d pressure %0h",
								got.k, $signed(got.t), got.p);
						end
					end
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

>>> tb/sv/baro_sensor_compensation_unit_tb.sv
// testbench top for the barometric compensation unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module baro_sensor_compensation_unit_tb;
	import baro_comp_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_WORDS    = 135;

	localparam logic [IDX_W-1:0]  REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0]  REG_SPARE_HI = 3'd7;
	localparam logic [COEF_W-1:0] COEF_MAX     = '1;
	localparam logic [RAW_W-1:0]  RAW_MAX      = '1;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_we      = 1'b0;
	logic [IDX_W-1:0]    cfg_index   = '0;
	logic [COEF_W-1:0]   cfg_data    = '0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic                op          = OP_TEMP;
	logic [RAW_W-1:0]    raw_reading = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic                kind;
	logic [TEMP_W-1:0]   temperature;
	logic [PRES_W-1:0]   pressure;

	int                  mismatches;
	int                  pending;
	int                  temp_words;
	int                  pres_words;
	int                  idle_cycles = 0;
	int                  settings_count = 0;
	int                  hold_count = 0;
	bit                  calm = 1'b0;
	bit                  hold_req = 1'b0;
	logic [COEF_W-1:0]   cur_ref = '0;

	baro_sensor_compensation_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.raw_reading (raw_reading),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.temperature (temperature),
		.pressure    (pressure)
	);

	baro_comp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.raw_reading (raw_reading),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.temperature (temperature),
		.pressure    (pressure),
		.mismatches  (mismatches),
		.pending     (pending),
		.temp_words  (temp_words),
		.pres_words  (pres_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_gap();
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return idle_length();
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return COEF_MAX;
		return COEF_W'($urandom());
	endfunction

	function automatic logic [RAW_W-1:0] rand_raw(input logic [COEF_W-1:0] ref_word);
		int r;
		int centre;
		int v;
		r      = $urandom_range(0, 99);
		centre = int'(ref_word) * 256;
		if (r < 8)
			return '0;
		if (r < 16)
			return RAW_MAX;
		if (r < 50) begin
			v = centre + int'($urandom_range(0, 2097152)) - 1048576;
			if (v < 0)
				v = 0;
			if (v > int'(RAW_MAX))
				v = int'(RAW_MAX);
			return v[RAW_W-1:0];
		end
		return RAW_W'($urandom());
	endfunction

	// receiver side: random stall runs, calm stretches and the long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_count++;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				out_stall <= 1'b1;
				repeat (idle_length() - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic load_config(input logic [COEF_W-1:0] c_sens, input logic [COEF_W-1:0] c_off,
		input logic [COEF_W-1:0] c_sens_tc, input logic [COEF_W-1:0] c_off_tc,
		input logic [COEF_W-1:0] c_ref, input logic [COEF_W-1:0] c_slope);
		write_cfg(REG_SENS, c_sens);
		write_cfg(REG_OFFSET, c_off);
		write_cfg(REG_SENS_TEMP, c_sens_tc);
		write_cfg(REG_OFF_TEMP, c_off_tc);
		write_cfg(REG_REF_TEMP, c_ref);
		write_cfg(REG_SLOPE, c_slope);
		cur_ref = c_ref;
		settings_count++;
	endtask

	task automatic send_word(input logic kind_op, input logic [RAW_W-1:0] value);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		op          <= kind_op;
		raw_reading <= value;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// let every outstanding word drain before touching the calibration
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// typical calibration, pressure before any temperature, ignored register indexes
		load_config(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
		write_cfg(REG_SPARE_LO, COEF_MAX);
		write_cfg(REG_SPARE_HI, 16'h5A5A);
		send_word(OP_PRES, '0);
		send_word(OP_PRES, RAW_MAX);
		send_word(OP_TEMP, RAW_W'(cur_ref) << 8);
		send_word(OP_TEMP, '0);
		send_word(OP_PRES, RAW_MAX);
		send_word(OP_PRES, '0);
		send_word(OP_TEMP, RAW_MAX);
		send_word(OP_PRES, RAW_MAX);
		send_word(OP_PRES, 24'd6465444);
		send_word(OP_TEMP, 24'd8077636);
		send_word(OP_PRES, 24'd6465444);
		quiesce();

		// all calibration words at their top, driving pressure negative
		load_config(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_word(OP_TEMP, '0);
		send_word(OP_PRES, RAW_MAX);
		send_word(OP_PRES, '0);
		send_word(OP_TEMP, RAW_MAX);
		send_word(OP_PRES, RAW_MAX);
		send_word(OP_PRES, 24'd1);
		quiesce();

		load_config('0, '0, '0, '0, '0, '0);
		send_word(OP_TEMP, RAW_MAX);
		send_word(OP_PRES, RAW_MAX);
		send_word(OP_TEMP, '0);
		send_word(OP_PRES, '0);
		quiesce();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm = (ph % 3 == 1);
			load_config(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef());
			write_cfg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
				COEF_W'($urandom()));
			if (ph == 2 || ph == 6)
				hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if ($urandom_range(0, 99) < 85) begin
					send_word(OP_TEMP, rand_raw(cur_ref));
					burst = $urandom_range(1, 5);
					repeat (burst) send_word(OP_PRES, rand_raw(cur_ref));
					sent += burst + 1;
				end else begin
					send_word(($urandom_range(0, 1) == 0) ? OP_TEMP : OP_PRES,
						rand_raw(cur_ref));
					sent++;
				end
			end
			quiesce();
		end

		$display("summary: %0d temperature and %0d pressure words checked", temp_words,
			pres_words);
		$display("summary: %0d calibration settings, %0d long receiver hold-offs",
			settings_count, hold_count);
		if (pending != 0)
			$display("%0d expected words never arrived", pending);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
